/* design/distance_vector_route_table_top_assert.svh */
// assertion macros shared by the route table checks
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_TOP_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DVRT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DVRT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dvrt_pkg.sv */
// ----------------------------------------------------------------------------
// dvrt_pkg
// types, constants and helpers of the distance-vector route table
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

  localparam int NODES     = 8;
  localparam int NODE_W    = 3;
  localparam int PORTS     = 4;
  localparam int PORT_W    = 2;
  localparam int PCNT_W    = 3;
  localparam int COST_W    = 8;
  localparam int TIME_BITS = 32;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_CHECK  = 2'd1,
    MODE_ADV    = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_SELF     = 3'd0,
    REG_STRATEGY = 3'd1,
    REG_INFINITY = 3'd2,
    REG_TIMEOUT  = 3'd3,
    REG_PCOUNT   = 3'd4,
    REG_NBRS     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    STRAT_NONE   = 2'd0,
    STRAT_SPLIT  = 2'd1,
    STRAT_POISON = 2'd2
  } strat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CHK,
    S_POIS,
    S_ADV,
    S_LOOK,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    EM_ADV,
    EM_HIT,
    EM_MISS
  } emit_t;

  typedef struct packed {
    logic [NODE_W-1:0]      self_node;
    logic [1:0]             strategy;
    logic [COST_W-1:0]      infinity_cost;
    logic [TIME_BITS-1:0]   timeout_ticks;
    logic [PCNT_W-1:0]      port_count;
    logic [PORTS*NODE_W-1:0] port_neighbors;
  } cfg_t;

  typedef struct packed {
    logic              latch_in;
    logic              stamp;
    logic              poison_wr;
    logic              clear_seen;
    logic              use_dest;
    logic              emit;
    emit_t             emit_kind;
    logic              flush;
    logic [NODE_W-1:0] d;
    logic [NODE_W-1:0] n;
    logic [PCNT_W-1:0] p;
  } cmd_t;

  typedef struct packed {
    logic upd_change;
    logic have_route;
    logic port_in_use;
    logic hop_match;
    logic split_skip;
    logic timed_out;
    logic poison_match;
    logic emit_ok;
    logic held_valid;
    logic flush_ok;
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [PORT_W-1:0] port;
    logic [NODE_W-1:0] dest;
    logic [COST_W-1:0] cost;
    logic              found;
    logic              last;
  } result_t;

  function automatic logic [NODE_W-1:0] neighbor_of(logic [PORTS*NODE_W-1:0] nbrs,
                                                    logic [PORT_W-1:0] p);
    return nbrs[p*NODE_W +: NODE_W];
  endfunction

endpackage

`default_nettype wire

/* design/dvrt_regs.sv */
// ----------------------------------------------------------------------------
// dvrt_regs
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_regs
  import dvrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_node      <= '0;
      cfg.strategy       <= '0;
      cfg.infinity_cost  <= COST_W'(16);
      cfg.timeout_ticks  <= TIME_BITS'(1000);
      cfg.port_count     <= PCNT_W'(4);
      cfg.port_neighbors <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SELF:     cfg.self_node      <= pwdata[NODE_W-1:0];
        REG_STRATEGY: cfg.strategy       <= pwdata[1:0];
        REG_INFINITY: cfg.infinity_cost  <= pwdata[COST_W-1:0];
        REG_TIMEOUT:  cfg.timeout_ticks  <= pwdata[TIME_BITS-1:0];
        REG_PCOUNT:   cfg.port_count     <= pwdata[PCNT_W-1:0];
        REG_NBRS:     cfg.port_neighbors <= pwdata[PORTS*NODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SELF:     prdata = DATA_W'(cfg.self_node);
      REG_STRATEGY: prdata = DATA_W'(cfg.strategy);
      REG_INFINITY: prdata = DATA_W'(cfg.infinity_cost);
      REG_TIMEOUT:  prdata = DATA_W'(cfg.timeout_ticks);
      REG_PCOUNT:   prdata = DATA_W'(cfg.port_count);
      REG_NBRS:     prdata = DATA_W'(cfg.port_neighbors);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/dvrt_datapath.sv */
// ----------------------------------------------------------------------------
// dvrt_datapath
// route and neighbor tables, timeout compare, result hold and output register
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_datapath
  import dvrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  cmd_t                 cmd,
  input  logic [NODE_W-1:0]    in_src,
  input  logic [NODE_W-1:0]    in_dest,
  input  logic [COST_W-1:0]    in_cost,
  input  logic [TIME_BITS-1:0] in_now,
  output status_t              status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_res
);

  logic [NODES-1:0]     route_valid;
  logic [NODE_W-1:0]    route_next_hop [NODES];
  logic [COST_W-1:0]    route_cost     [NODES];
  logic [NODES-1:0]     seen_valid;
  logic [TIME_BITS-1:0] last_seen_time [NODES];

  logic [NODE_W-1:0]    src_q, dest_q;
  logic [COST_W-1:0]    cost_q;
  logic [TIME_BITS-1:0] now_q;

  logic [NODE_W-1:0]    addr, hop, nb;
  logic [COST_W-1:0]    cur_cost, nc, upd_cost, adv_cost;
  logic [PCNT_W-1:0]    nports;
  logic [TIME_BITS-1:0] age;
  logic                 is_self, rv;
  logic                 held_valid;
  logic                 upd_change;
  result_t              held, new_res, flush_res;
  logic                 can_push;

  assign addr     = cmd.use_dest ? dest_q : cmd.d;
  assign is_self  = (addr == cfg.self_node);
  assign rv       = route_valid[addr];
  assign hop      = is_self ? cfg.self_node : route_next_hop[addr];
  assign cur_cost = is_self ? '0 : route_cost[addr];
  assign nc       = (cost_q == COST_MAX) ? COST_MAX : cost_q + COST_W'(1);
  assign nports   = (cfg.port_count > PCNT_W'(PORTS)) ? PCNT_W'(PORTS) : cfg.port_count;
  assign nb       = neighbor_of(cfg.port_neighbors, cmd.p[PORT_W-1:0]);
  assign age      = now_q - last_seen_time[cmd.n];

  // decide whether the update changes the route and the cost it leaves
  always_comb begin
    upd_change = 1'b0;
    upd_cost   = nc;
    if (!is_self) begin
      if (!rv || route_cost[addr] > nc) begin
        upd_change = 1'b1;
      end else if (route_cost[addr] < nc && route_next_hop[addr] == src_q) begin
        upd_change = 1'b1;
        upd_cost   = (cost_q == cfg.infinity_cost) ? cfg.infinity_cost : nc;
      end
    end
  end

  assign status.upd_change   = upd_change;
  assign status.have_route   = is_self || rv;
  assign status.port_in_use  = cmd.p < nports;
  assign status.hop_match    = (nb == hop);
  assign status.split_skip   = (cfg.strategy == STRAT_SPLIT) && (nb == hop);
  assign status.timed_out    = seen_valid[cmd.n] && (age > cfg.timeout_ticks);
  assign status.poison_match = !is_self && rv && (route_next_hop[addr] == cmd.n);

  assign adv_cost = ((cfg.strategy == STRAT_POISON) && (nb == hop)) ? cfg.infinity_cost
                                                                   : cur_cost;

  always_comb begin
    new_res = '0;
    unique case (cmd.emit_kind)
      EM_ADV: begin
        new_res.port = cmd.p[PORT_W-1:0];
        new_res.dest = addr;
        new_res.cost = adv_cost;
      end
      EM_HIT: begin
        new_res.kind  = 1'b1;
        new_res.port  = cmd.p[PORT_W-1:0];
        new_res.dest  = addr;
        new_res.found = 1'b1;
      end
      default: begin
        new_res.kind = 1'b1;
        new_res.dest = addr;
      end
    endcase
  end

  // the held result marked as the last of its request
  always_comb begin
    flush_res      = held;
    flush_res.last = 1'b1;
  end

  assign can_push          = !out_valid || out_ready;
  assign status.emit_ok    = !held_valid || can_push;
  assign status.held_valid = held_valid;
  assign status.flush_ok   = can_push;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      src_q  <= in_src;
      dest_q <= in_dest;
      cost_q <= in_cost;
      now_q  <= in_now;
    end
    if (cmd.stamp) begin
      last_seen_time[src_q] <= now_q;
      if (upd_change) begin
        route_next_hop[addr] <= src_q;
        route_cost[addr]     <= upd_cost;
      end
    end
    if (cmd.poison_wr) begin
      route_cost[addr] <= cfg.infinity_cost;
    end
    if (cmd.emit) begin
      held <= new_res;
    end
    if (cmd.emit && held_valid) begin
      out_res <= held;
    end else if (cmd.flush) begin
      out_res <= flush_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_valid <= '0;
      seen_valid  <= '0;
      held_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.stamp) begin
        seen_valid[src_q] <= 1'b1;
        if (upd_change) begin
          route_valid[addr] <= 1'b1;
        end
      end
      if (cmd.clear_seen) begin
        seen_valid[cmd.n] <= 1'b0;
      end
      if (cmd.emit) begin
        held_valid <= 1'b1;
      end else if (cmd.flush) begin
        held_valid <= 1'b0;
      end
      if ((cmd.emit && held_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/dvrt_ctrl.sv */
// ----------------------------------------------------------------------------
// dvrt_ctrl
// sequencer over nodes, routes and ports for one request at a time
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_ctrl
  import dvrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  output logic       in_ready,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

  state_t            state, state_next;
  mode_t             mode, mode_next;
  logic [NODE_W-1:0] d, d_next, n, n_next;
  logic [PCNT_W-1:0] p, p_next;
  logic              route_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_UPDATE;
      d     <= '0;
      n     <= '0;
      p     <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      d     <= d_next;
      n     <= n_next;
      p     <= p_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    mode_next  = mode;
    d_next     = d;
    n_next     = n;
    p_next     = p;
    route_done = 1'b0;
    cmd        = '0;
    cmd.emit_kind = EM_ADV;
    cmd.d      = d;
    cmd.n      = n;
    cmd.p      = p;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          mode_next    = mode_t'(in_mode);
          d_next       = '0;
          n_next       = '0;
          p_next       = '0;
          unique case (mode_t'(in_mode))
            MODE_UPDATE: state_next = S_UPD;
            MODE_CHECK:  state_next = S_CHK;
            MODE_ADV:    state_next = S_ADV;
            default:     state_next = S_LOOK;
          endcase
        end
      end
      S_UPD: begin
        cmd.use_dest = 1'b1;
        cmd.stamp    = 1'b1;
        p_next       = '0;
        state_next   = status.upd_change ? S_ADV : S_FIN;
      end
      S_CHK: begin
        if (status.timed_out) begin
          d_next     = '0;
          state_next = S_POIS;
        end else if (n == LAST_NODE) begin
          state_next = S_FIN;
        end else begin
          n_next = n + NODE_W'(1);
        end
      end
      S_POIS: begin
        if (status.poison_match) begin
          cmd.poison_wr = 1'b1;
          p_next        = '0;
          state_next    = S_ADV;
        end else begin
          route_done = 1'b1;
        end
      end
      S_ADV: begin
        cmd.use_dest = (mode == MODE_UPDATE);
        if (!status.have_route || !status.port_in_use) begin
          route_done = 1'b1;
        end else if (status.split_skip) begin
          p_next = p + PCNT_W'(1);
        end else if (status.emit_ok) begin
          cmd.emit = 1'b1;
          p_next   = p + PCNT_W'(1);
        end
      end
      S_LOOK: begin
        cmd.use_dest = 1'b1;
        if (status.have_route && status.port_in_use && !status.hop_match) begin
          p_next = p + PCNT_W'(1);
        end else if (status.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = (status.have_route && status.port_in_use) ? EM_HIT : EM_MISS;
          state_next    = S_FIN;
        end
      end
      S_FIN: begin
        if (!status.held_valid) begin
          state_next = S_IDLE;
        end else if (status.flush_ok) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // once a route is advertised or passed over, step to the next route, the next node, or finish
    if (route_done) begin
      p_next = '0;
      unique case (mode)
        MODE_ADV: begin
          if (d == LAST_NODE) begin
            state_next = S_FIN;
          end else begin
            d_next     = d + NODE_W'(1);
            state_next = S_ADV;
          end
        end
        MODE_CHECK: begin
          if (d == LAST_NODE) begin
            cmd.clear_seen = 1'b1;
            if (n == LAST_NODE) begin
              state_next = S_FIN;
            end else begin
              n_next     = n + NODE_W'(1);
              state_next = S_CHK;
            end
          end else begin
            d_next     = d + NODE_W'(1);
            state_next = S_POIS;
          end
        end
        default: state_next = S_FIN;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/distance_vector_route_table_top.sv */
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// distance-vector route table with per-port advertising and port lookup
// ----------------------------------------------------------------------------
// One request is worked at a time; s_tready is high only while the sequencer
// is idle. A neighbor update stamps the source and, when the route changes,
// advertises it on each port in use. An advertise-all request walks every
// node and every port. A check-alive request walks every neighbor node;
// for each timed-out neighbor it walks every route and advertises each
// route it poisons. A lookup searches the ports in use for the next hop.
// The sequencer steps route, node and port counters, and stalls on m_tready
// hold it. Results leave through a one-deep hold and an output register, so
// the last result of a request is marked on m_tlast. Route and seen valid
// bits clear at reset; no clearing pass is needed.
`default_nettype none

module distance_vector_route_table_top
  import dvrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // apb configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // request stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,  // source_node[2:0] dest_node[5:3] cost[13:6] now[45:14]
  input  logic [1:0]        s_tuser,  // mode[1:0]
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,  // out_port[1:0] adv_dest[4:2] adv_cost[12:5]
                                      // route_found[13]
  output logic [0:0]        m_tuser,  // result_kind[0]
  output logic              m_tlast   // last_item
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  result_t res;

  assign pready = 1'b1;

  dvrt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: one request at a time
  dvrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // tables, compare and result staging
  dvrt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_src    (s_tdata[2:0]),
    .in_dest   (s_tdata[5:3]),
    .in_cost   (s_tdata[13:6]),
    .in_now    (s_tdata[45:14]),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // pack the result fields, lowest first
  assign m_tdata = {2'b00, res.found, res.cost, res.dest, res.port};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  `include "distance_vector_route_table_top_assert.svh"

  // a new request never starts with a result still held back
  `DVRT_ASSERT_NOW(a_idle_hold_empty, clk, rst, s_tready, !status.held_valid, "held result at accept")
  // after accepting a request the block is busy
  `DVRT_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "ready after accept")
  // a result is only pushed out when the output register can take it
  `DVRT_ASSERT_NOW(a_push_room, clk, rst, cmd.flush, !m_tvalid || m_tready, "push into full output")

endmodule

`default_nettype wire

/* sim/distance_vector_route_table_top_tb.sv */
// ----------------------------------------------------------------------------
// distance_vector_route_table_top_tb
// self-checking bench for the distance-vector route table
// ----------------------------------------------------------------------------
// Requests are driven on the request stream and mirrored into a route table
// model kept inside a small scoreboard class. That model predicts every
// advertisement and lookup answer, and each result that leaves the block is
// compared field by field with the oldest prediction. Registers are written
// over the apb port only while the block is idle.
`default_nettype none

module distance_vector_route_table_top_tb;
  import dvrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted or observed result
  typedef struct packed {
    logic              kind;
    logic [PORT_W-1:0] port;
    logic [NODE_W-1:0] dest;
    logic [COST_W-1:0] cost;
    logic              found;
    logic              last;
  } route_msg_t;

  // route table model and queue of pending results
  class route_scoreboard;
    logic [NODE_W-1:0]    my_node;
    logic [1:0]           adv_rule;
    logic [COST_W-1:0]    inf_cost;
    logic [TIME_BITS-1:0] age_limit;
    logic [PCNT_W-1:0]    nports;
    logic [PORTS*NODE_W-1:0] nbr_map;
    logic                 rt_ok   [NODES];
    logic [NODE_W-1:0]    rt_hop  [NODES];
    logic [COST_W-1:0]    rt_cost [NODES];
    logic                 nb_seen [NODES];
    logic [TIME_BITS-1:0] nb_stamp[NODES];
    route_msg_t           pending[$];
    route_msg_t           burst[$];
    int                   errors;
    int                   checked;

    function new();
      my_node = 0; adv_rule = 0; inf_cost = 16; age_limit = 1000;
      nports = 4; nbr_map = 0; errors = 0; checked = 0;
      for (int i = 0; i < NODES; i++) begin
        rt_ok[i] = 0; nb_seen[i] = 0; rt_hop[i] = 0; rt_cost[i] = 0; nb_stamp[i] = 0;
      end
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_SELF:     my_node = v[2:0];
        REG_STRATEGY: adv_rule = v[1:0];
        REG_INFINITY: inf_cost = v[7:0];
        REG_TIMEOUT:  age_limit = v;
        REG_PCOUNT:   nports = v[2:0];
        REG_NBRS:     nbr_map = v[11:0];
        default: ;
      endcase
    endfunction

    function int live_ports();
      return (nports > PORTS) ? PORTS : nports;
    endfunction

    function void push(logic k, int p, int d, logic [7:0] c, logic f);
      route_msg_t m;
      if (burst.size() >= 32) return;
      m.kind = k; m.port = p[PORT_W-1:0]; m.dest = d[NODE_W-1:0];
      m.cost = c; m.found = f; m.last = 0;
      burst.push_back(m);
    endfunction

    function logic [2:0] nbr(int p);
      return nbr_map[3*p +: 3];
    endfunction

    function void send_route(int d);
      logic [2:0] hop;
      logic [7:0] c;
      if (d == my_node) begin
        hop = my_node; c = 0;
      end else if (rt_ok[d]) begin
        hop = rt_hop[d]; c = rt_cost[d];
      end else return;
      for (int p = 0; p < live_ports(); p++) begin
        if (adv_rule == STRAT_SPLIT && nbr(p) == hop) continue;
        push(0, p, d, (adv_rule == STRAT_POISON && nbr(p) == hop) ? inf_cost : c, 0);
      end
    endfunction

    // note an accepted request and predict its results
    function void note_request(mode_t md, logic [2:0] src, logic [2:0] dst,
                               logic [7:0] c, logic [31:0] now);
      logic [7:0] nc;
      logic [2:0] hop;
      logic       hit;
      burst.delete();
      case (md)
        MODE_UPDATE: begin
          nc = (c == 8'hff) ? 8'hff : c + 8'd1;
          nb_seen[src] = 1; nb_stamp[src] = now;
          if (dst != my_node) begin
            if (!rt_ok[dst]) begin
              rt_ok[dst] = 1; rt_hop[dst] = src; rt_cost[dst] = nc; send_route(dst);
            end else if (rt_cost[dst] > nc) begin
              rt_hop[dst] = src; rt_cost[dst] = nc; send_route(dst);
            end else if (rt_cost[dst] < nc && rt_hop[dst] == src) begin
              rt_cost[dst] = (c == inf_cost) ? inf_cost : nc; send_route(dst);
            end
          end
        end
        MODE_CHECK: begin
          for (int n = 0; n < NODES; n++) begin
            if (!nb_seen[n] || (now - nb_stamp[n]) <= age_limit) continue;
            for (int d = 0; d < NODES; d++) begin
              if (d == my_node || !rt_ok[d] || rt_hop[d] != n) continue;
              rt_cost[d] = inf_cost; send_route(d);
            end
            nb_seen[n] = 0;
          end
        end
        MODE_ADV: for (int d = 0; d < NODES; d++) send_route(d);
        default: begin
          hit = 0;
          if (dst == my_node || rt_ok[dst]) begin
            hop = (dst == my_node) ? my_node : rt_hop[dst];
            for (int p = 0; p < live_ports(); p++)
              if (!hit && nbr(p) == hop) begin
                push(1, p, dst, 0, 1); hit = 1;
              end
          end
          if (!hit) push(1, 0, dst, 0, 0);
        end
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last = 1;
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    // compare one result with the oldest prediction
    function void check_result(route_msg_t got);
      route_msg_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, got);
        return;
      end
      e = pending.pop_front();
      if (e.kind !== got.kind) begin
        errors++; $display("%0t: result_kind exp %0d got %0d", $realtime, e.kind, got.kind);
      end
      if (e.port !== got.port) begin
        errors++; $display("%0t: out_port exp %0d got %0d", $realtime, e.port, got.port);
      end
      if (e.dest !== got.dest) begin
        errors++; $display("%0t: adv_dest exp %0d got %0d", $realtime, e.dest, got.dest);
      end
      if (e.cost !== got.cost) begin
        errors++; $display("%0t: adv_cost exp %0d got %0d", $realtime, e.cost, got.cost);
      end
      if (e.found !== got.found) begin
        errors++; $display("%0t: route_found exp %0d got %0d", $realtime, e.found, got.found);
      end
      if (e.last !== got.last) begin
        errors++; $display("%0t: last_item exp %0d got %0d", $realtime, e.last, got.last);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              pready;
  logic              s_tvalid, s_tready;
  logic [47:0]       s_tdata;   // source_node[2:0] dest_node[5:3] cost[13:6] now[45:14]
  logic [1:0]        s_tuser;   // mode[1:0]
  logic              m_tvalid, m_tready;
  logic [15:0]       m_tdata;   // out_port[1:0] adv_dest[4:2] adv_cost[12:5] route_found[13]
  logic [0:0]        m_tuser;   // result_kind[0]
  logic              m_tlast;

  route_scoreboard table_sb;
  int  idle_cycles;
  int  reqs_sent;
  bit  hold_off;      // long receiver stall requested by stimulus
  bit  quiet_sink;    // no random sink stalls
  logic [31:0] clock_now;

  distance_vector_route_table_top uut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // short gaps mostly, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stalls, and the long hold-off when asked
  initial begin
    int g;
    m_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      g = quiet_sink ? 0 : gap_len();
      if (g > 0) begin
        m_tready <= 0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
    end
  end

  // sample accepted results
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      route_msg_t got;
      got.kind = m_tuser[0]; got.port = m_tdata[1:0]; got.dest = m_tdata[4:2];
      got.cost = m_tdata[12:5]; got.found = m_tdata[13]; got.last = m_tlast;
      table_sb.check_result(got);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(4 * idx); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    table_sb.write_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one request, with an optional gap before it; valid held across items
  task automatic send_req(mode_t md, logic [2:0] src, logic [2:0] dst,
                          logic [7:0] c, logic [31:0] now, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= md;
    s_tdata  <= {2'b0, now, c, dst, src};
    @(posedge clk iff s_tready);
    table_sb.note_request(md, src, dst, c, now);
    reqs_sent++;
  endtask

  // let the block drain before register writes
  task automatic drain();
    s_tvalid <= 0;
    while (table_sb.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic rand_req();
    int r;
    mode_t md;
    r = $urandom_range(0, 99);
    md = (r < 55) ? MODE_UPDATE : (r < 68) ? MODE_CHECK : (r < 76) ? MODE_ADV : MODE_LOOKUP;
    clock_now = clock_now + $urandom_range(0, 600);
    if ($urandom_range(0, 19) == 0) clock_now = $urandom;
    send_req(md, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
             8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, 20)),
             clock_now);
  endtask

  task automatic phase(logic [2:0] me, logic [1:0] rule, logic [7:0] inf, logic [31:0] tmo,
                       logic [2:0] np, logic [11:0] nbrs, int count);
    reg_write(REG_SELF, me);
    reg_write(REG_STRATEGY, rule);
    reg_write(REG_INFINITY, inf);
    reg_write(REG_TIMEOUT, tmo);
    reg_write(REG_PCOUNT, np);
    reg_write(REG_NBRS, nbrs);
    repeat (count) rand_req();
    drain();
  endtask

  initial begin
    table_sb = new();
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0;
    idle_cycles = 0; reqs_sent = 0; hold_off = 0; quiet_sink = 0; clock_now = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, then poison reverse with wired neighbors
    send_req(MODE_LOOKUP, 0, 0, 0, 0);            // self route lookup, hits port 0 as neighbors reset to node 0
    send_req(MODE_ADV, 0, 0, 0, 0);               // only the self route exists
    drain();
    reg_write(REG_STRATEGY, STRAT_POISON);
    reg_write(REG_NBRS, {3'd4, 3'd3, 3'd2, 3'd1});
    send_req(MODE_UPDATE, 1, 5, 3, 10);           // new route
    send_req(MODE_UPDATE, 2, 5, 1, 20);           // cheaper
    send_req(MODE_UPDATE, 2, 5, 9, 30);           // rise from next hop
    send_req(MODE_UPDATE, 2, 5, 16, 40);          // next hop reports infinity
    send_req(MODE_UPDATE, 3, 6, 255, 50);         // saturating cost
    send_req(MODE_UPDATE, 3, 0, 2, 60);           // names self, ignored
    send_req(MODE_UPDATE, 7, 7, 0, 32'hffff_fff0); // extremes of the fields
    send_req(MODE_UPDATE, 4, 2, 5, 32'hffff_ffff);
    send_req(MODE_LOOKUP, 0, 5, 0, 0);
    send_req(MODE_LOOKUP, 0, 3, 0, 0);            // no route
    send_req(MODE_LOOKUP, 0, 6, 0, 0);
    send_req(MODE_CHECK, 0, 0, 0, 500);           // timer wrap, 7 and 4 still fresh
    send_req(MODE_CHECK, 0, 0, 0, 5000);          // everyone timed out
    send_req(MODE_ADV, 0, 0, 0, 0);
    drain();
    reg_write(REG_STRATEGY, 2'd3);                // undefined rule acts as none
    reg_write(REG_PCOUNT, 3'd7);                  // above the port count
    send_req(MODE_ADV, 0, 0, 0, 0);
    drain();
    reg_write(REG_PCOUNT, 3'd0);                  // no port in use
    send_req(MODE_ADV, 0, 0, 0, 0);
    send_req(MODE_LOOKUP, 0, 0, 0, 0);
    send_req(MODE_UPDATE, 1, 1, 0, 0);
    drain();

    // receiver holds off long while requests keep coming
    reg_write(REG_PCOUNT, 3'd4);
    hold_off = 1;
    repeat (6) send_req(MODE_ADV, 0, 0, 0, 0, 0);
    drain();

    // random phases over several register settings, extremes included
    phase(3'd0, STRAT_NONE,   8'd16,  32'd1000,     3'd4, 12'o4321, 60);
    phase(3'd7, STRAT_SPLIT,  8'd1,   32'd0,        3'd1, 12'o7777, 50);
    phase(3'd3, STRAT_POISON, 8'd255, 32'hffffffff, 3'd3, 12'o0123, 50);
    quiet_sink = 1;
    phase(3'd5, STRAT_POISON, 8'd20,  32'd700,      3'd4, 12'o6135, 60);
    quiet_sink = 0;
    phase(3'd2, STRAT_SPLIT,  8'd16,  32'd400,      3'd2, 12'o5710, 60);
    phase(3'd1, 2'd3,         8'd8,   32'd900,      3'd5, 12'o2460, 60);

    $display("ran %0d requests, %0d results checked, across strategies, port counts",
             reqs_sent, table_sb.checked);
    $display("and timeouts including wrap, saturation, and poisoning");
    if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
